// File: rtl/hid_report_field_access_assert.svh
// ---------------------------------------------------------------------------
// HID report field access assertion macros
// Clocked assertion wrappers shared by the block's modules.
// ---------------------------------------------------------------------------
`ifndef HID_REPORT_FIELD_ACCESS_ASSERT_SVH
`define HID_REPORT_FIELD_ACCESS_ASSERT_SVH

// Check while out of reset.
`define HRFA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check at every edge, reset included.
`define HRFA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/hrfa_pkg.sv
// ---------------------------------------------------------------------------
// hrfa_pkg
// Shared types and constants of the HID report field access block.
// ---------------------------------------------------------------------------
package hrfa_pkg;

    localparam int REPORT_BYTES_DEF = 64;
    localparam int ID_BITS          = 8;
    localparam int MAX_FIELD        = 32;
    localparam int FIELD_BYTES      = 5;
    localparam int SPAN_BITS        = FIELD_BYTES * 8;

    typedef enum logic [1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_INSERT  = 2'd2,
        FUNC_EXTRACT = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_EXT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } mem_ctl_t;

endpackage

// File: rtl/hrfa_channels.sv
// ---------------------------------------------------------------------------
// hrfa channels
// Valid/ready request and response channels of the field access block.
// ---------------------------------------------------------------------------
interface hrfa_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [5:0]         byte_index;
    logic [7:0]         byte_data;
    logic [7:0]         bit_offset;
    logic [5:0]         field_size;
    logic signed [32:0] log_min;
    logic signed [32:0] log_max;
    logic [31:0]        write_bits;

    modport source (
        output valid, func, byte_index, byte_data, bit_offset, field_size,
               log_min, log_max, write_bits,
        input  ready
    );
    modport sink (
        input  valid, func, byte_index, byte_data, bit_offset, field_size,
               log_min, log_max, write_bits,
        output ready
    );
endinterface

interface hrfa_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [32:0] field_value;
    logic [7:0]         byte_out;

    modport source (
        output valid, field_value, byte_out,
        input  ready
    );
    modport sink (
        input  valid, field_value, byte_out,
        output ready
    );
endinterface

// File: rtl/hrfa_store.sv
// ---------------------------------------------------------------------------
// hrfa_store
// Report byte memory: one write and one read port, registered read data,
// per-byte valid flags so that a never-written byte reads as zero.
// ---------------------------------------------------------------------------
`include "hid_report_field_access_assert.svh"

module hrfa_store #(
    parameter int REPORT_BYTES = hrfa_pkg::REPORT_BYTES_DEF,
    localparam int AW          = $clog2(REPORT_BYTES)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hrfa_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]      raddr,
    input  logic [AW-1:0]      waddr,
    input  logic [7:0]         wdata,
    output logic [7:0]         rdata
);

    logic [7:0]              mem [REPORT_BYTES];
    logic [REPORT_BYTES-1:0] valid_reg;
    logic [7:0]              rd_data_reg;
    logic                    rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.rd)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (ctl.rd)
            begin
                rd_ok_reg <= valid_reg[raddr];
            end
        end
    end

    // bytes not written since reset read as zero
    assign rdata = rd_ok_reg ? rd_data_reg : 8'h00;

    `HRFA_ASSERT_ALWAYS(a_no_same_entry, (ctl.rd && ctl.wr) |-> (raddr != waddr), "read and write hit the same byte")

endmodule

// File: rtl/hrfa_extract.sv
// ---------------------------------------------------------------------------
// hrfa_extract
// Two-stage field post-processing: align and mask the gathered bytes, find
// the magnitude mask, then sign-extend and clamp to the logical range.
// ---------------------------------------------------------------------------
module hrfa_extract (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [hrfa_pkg::SPAN_BITS-1:0] gather,
    input  logic [2:0]                     sh,
    input  logic [31:0]                    fmask,
    input  logic signed [32:0]             log_min,
    input  logic signed [32:0]             log_max,
    output logic                           done,
    output logic signed [32:0]             value
);

    logic [hrfa_pkg::SPAN_BITS-1:0] shifted;
    logic [31:0]                    raw;
    logic [31:0]                    mlo;
    logic [31:0]                    mhi;
    logic [31:0]                    mmax;
    logic [31:0]                    sm1, sm2, sm4, sm8, sm16;
    logic [31:0]                    raw_reg;
    logic [31:0]                    ml_reg;
    logic                           s1_valid_reg;
    logic                           done_reg;
    logic signed [32:0]             value_reg;
    logic signed [32:0]             value_next;
    logic [32:0]                    ml33;
    logic [32:0]                    sign33;
    logic [32:0]                    mask33;
    logic [32:0]                    raw33;
    logic [32:0]                    val33;
    logic                           neg;

    // stage 1: align field, magnitude of each bound, fill ones below top bit
    always_comb
    begin
        shifted = gather >> sh;
        raw     = shifted[31:0] & fmask;
        mlo     = log_min[32] ? ~log_min[31:0] : log_min[31:0];
        mhi     = log_max[32] ? ~log_max[31:0] : log_max[31:0];
        mmax    = (mhi > mlo) ? mhi : mlo;
        sm1     = mmax | (mmax >> 1);
        sm2     = sm1 | (sm1 >> 2);
        sm4     = sm2 | (sm2 >> 4);
        sm8     = sm4 | (sm4 >> 8);
        sm16    = sm8 | (sm8 >> 16);
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            raw_reg <= raw;
            ml_reg  <= sm16;
        end
        if (s1_valid_reg)
        begin
            value_reg <= value_next;
        end
    end

    // stage 2: sign handling and clamp, lower bound tested first
    always_comb
    begin
        ml33   = {1'b0, ml_reg};
        sign33 = ml33 + 33'd1;
        mask33 = ml33 | (log_min[32] ? sign33 : 33'd0);
        raw33  = {1'b0, raw_reg} & mask33;
        neg    = log_min[32] && ((raw33 & sign33) != 33'd0);
        val33  = neg ? (raw33 | ~ml33) : raw33;
        if ($signed(val33) < log_min)
        begin
            value_next = log_min;
        end
        else if ($signed(val33) > log_max)
        begin
            value_next = log_max;
        end
        else
        begin
            value_next = $signed(val33);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            done_reg     <= s1_valid_reg;
        end
    end

    assign done  = done_reg;
    assign value = value_reg;

endmodule

// File: rtl/hid_report_field_access.sv
// An item is accepted only in the idle state, so the next one waits until
// the previous result has moved to the output register. For insert and
// extract, the byte-serial walk over the five report bytes a field can touch,
// via one read and one write port of the report memory, takes the most time.
// Reset is asynchronous and active low; the report reads as all zero after
// reset through per-byte valid flags, so no clearing pass is needed.
// ---------------------------------------------------------------------------
// hid_report_field_access
// HID report buffer with byte load/read and bit-field insert/extract.
// ---------------------------------------------------------------------------
`include "hid_report_field_access_assert.svh"

module hid_report_field_access #(
    parameter int REPORT_BYTES = hrfa_pkg::REPORT_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    hrfa_req_if.sink    req,
    hrfa_rsp_if.source  rsp
);

    localparam int AW = $clog2(REPORT_BYTES);
    localparam int SB = hrfa_pkg::SPAN_BITS;
    localparam logic [8:0] DEPTH9 = 9'(REPORT_BYTES);
    localparam logic [2:0] LAST_CNT = 3'(hrfa_pkg::FIELD_BYTES);

    hrfa_pkg::state_t   state_reg, state_next;
    hrfa_pkg::func_t    func_reg, func_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               idx_ok_reg, idx_ok_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [7:0]         data_reg, data_next;
    logic [AW-1:0]      base_reg, base_next;
    logic [2:0]         sh_reg, sh_next;
    logic [31:0]        fmask_reg, fmask_next;
    logic [SB-1:0]      ins_data_reg, ins_data_next;
    logic [SB-1:0]      ins_mask_reg, ins_mask_next;
    logic [SB-1:0]      gather_reg, gather_next;
    logic signed [32:0] lo_reg, lo_next;
    logic signed [32:0] hi_reg, hi_next;
    logic signed [32:0] res_fv_reg, res_fv_next;
    logic [7:0]         res_bo_reg, res_bo_next;
    logic               ext_go_reg, ext_go_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [32:0] out_fv_reg, out_fv_next;
    logic [7:0]         out_bo_reg, out_bo_next;

    hrfa_pkg::mem_ctl_t mem_ctl;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;
    logic [7:0]         wdata;
    logic [7:0]         rdata;
    logic               ext_done;
    logic signed [32:0] ext_value;

    hrfa_store #(
        .REPORT_BYTES (REPORT_BYTES)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mem_ctl),
        .raddr (raddr),
        .waddr (waddr),
        .wdata (wdata),
        .rdata (rdata)
    );

    hrfa_extract u_extract (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ext_go_reg),
        .gather  (gather_reg),
        .sh      (sh_reg),
        .fmask   (fmask_reg),
        .log_min (lo_reg),
        .log_max (hi_reg),
        .done    (ext_done),
        .value   (ext_value)
    );

    assign req.ready       = (state_reg == hrfa_pkg::S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.field_value = out_fv_reg;
    assign rsp.byte_out    = out_bo_reg;

    always_comb
    begin
        logic [5:0]  size_c;
        logic [31:0] fmask_c;

        state_next     = state_reg;
        func_next      = func_reg;
        cnt_next       = cnt_reg;
        idx_ok_next    = idx_ok_reg;
        idx_next       = idx_reg;
        data_next      = data_reg;
        base_next      = base_reg;
        sh_next        = sh_reg;
        fmask_next     = fmask_reg;
        ins_data_next  = ins_data_reg;
        ins_mask_next  = ins_mask_reg;
        gather_next    = gather_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        res_fv_next    = res_fv_reg;
        res_bo_next    = res_bo_reg;
        ext_go_next    = 1'b0;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_fv_next    = out_fv_reg;
        out_bo_next    = out_bo_reg;
        mem_ctl        = '0;
        raddr          = base_reg + AW'(cnt_reg);
        waddr          = base_reg + AW'(cnt_reg) - AW'(1);
        wdata          = (rdata & ~ins_mask_reg[7:0]) | ins_data_reg[7:0];

        size_c  = (req.field_size > 6'(hrfa_pkg::MAX_FIELD)) ?
                  6'(hrfa_pkg::MAX_FIELD) : req.field_size;
        fmask_c = size_c[5] ? 32'hFFFF_FFFF : ((32'd1 << size_c[4:0]) - 32'd1);

        unique case (state_reg)
            hrfa_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next     = hrfa_pkg::func_t'(req.func);
                    cnt_next      = 3'd0;
                    idx_ok_next   = ({3'b000, req.byte_index} < DEPTH9);
                    idx_next      = AW'(req.byte_index);
                    data_next     = req.byte_data;
                    // field starts one byte in, past the report ID
                    base_next     = AW'({1'b0, req.bit_offset[7:3]} +
                                        6'(hrfa_pkg::ID_BITS / 8));
                    sh_next       = req.bit_offset[2:0];
                    fmask_next    = fmask_c;
                    ins_data_next = {8'h00, req.write_bits & fmask_c} << req.bit_offset[2:0];
                    ins_mask_next = {8'h00, fmask_c} << req.bit_offset[2:0];
                    lo_next       = req.log_min;
                    hi_next       = req.log_max;
                    res_fv_next   = '0;
                    res_bo_next   = 8'h00;
                    state_next    = hrfa_pkg::S_RUN;
                end
            end

            hrfa_pkg::S_RUN:
            begin
                unique case (func_reg) inside
                    hrfa_pkg::FUNC_LOAD:
                    begin
                        mem_ctl.wr = idx_ok_reg;
                        waddr      = idx_reg;
                        wdata      = data_reg;
                        state_next = hrfa_pkg::S_DONE;
                    end
                    hrfa_pkg::FUNC_READ:
                    begin
                        raddr = idx_reg;
                        if (cnt_reg == 3'd0)
                        begin
                            mem_ctl.rd = idx_ok_reg;
                            cnt_next   = 3'd1;
                        end
                        else
                        begin
                            res_bo_next = idx_ok_reg ? rdata : 8'h00;
                            state_next  = hrfa_pkg::S_DONE;
                        end
                    end
                    hrfa_pkg::FUNC_INSERT, hrfa_pkg::FUNC_EXTRACT:
                    begin
                        // read byte cnt, while byte cnt-1 comes back
                        mem_ctl.rd = (cnt_reg != LAST_CNT);
                        if (cnt_reg != 3'd0)
                        begin
                            if (func_reg == hrfa_pkg::FUNC_INSERT)
                            begin
                                mem_ctl.wr    = 1'b1;
                                ins_data_next = ins_data_reg >> 8;
                                ins_mask_next = ins_mask_reg >> 8;
                            end
                            else
                            begin
                                gather_next = {rdata, gather_reg[SB-1:8]};
                            end
                        end
                        if (cnt_reg == LAST_CNT)
                        begin
                            if (func_reg == hrfa_pkg::FUNC_INSERT)
                            begin
                                state_next = hrfa_pkg::S_DONE;
                            end
                            else
                            begin
                                ext_go_next = 1'b1;
                                state_next  = hrfa_pkg::S_EXT;
                            end
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 3'd1;
                        end
                    end
                endcase
            end

            hrfa_pkg::S_EXT:
            begin
                if (ext_done)
                begin
                    res_fv_next = ext_value;
                    state_next  = hrfa_pkg::S_DONE;
                end
            end

            hrfa_pkg::S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_fv_next    = res_fv_reg;
                    out_bo_next    = res_bo_reg;
                    state_next     = hrfa_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hrfa_pkg::S_IDLE;
            cnt_reg       <= 3'd0;
            ext_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ext_go_reg    <= ext_go_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        idx_ok_reg   <= idx_ok_next;
        idx_reg      <= idx_next;
        data_reg     <= data_next;
        base_reg     <= base_next;
        sh_reg       <= sh_next;
        fmask_reg    <= fmask_next;
        ins_data_reg <= ins_data_next;
        ins_mask_reg <= ins_mask_next;
        gather_reg   <= gather_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        res_fv_reg   <= res_fv_next;
        res_bo_reg   <= res_bo_next;
        out_fv_reg   <= out_fv_next;
        out_bo_reg   <= out_bo_next;
    end

    `HRFA_ASSERT(a_accept_leaves_idle, (req.valid && req.ready) |=> (state_reg != hrfa_pkg::S_IDLE), "item accepted but sequencer stayed idle")
    `HRFA_ASSERT(a_ext_done_in_ext, ext_done |-> (state_reg == hrfa_pkg::S_EXT), "extract result outside extract wait")
    `HRFA_ASSERT(a_fv_zero_not_extract, ((state_reg == hrfa_pkg::S_DONE) && (func_reg != hrfa_pkg::FUNC_EXTRACT)) |-> (res_fv_reg == 33'sd0), "field value set by non-extract item")
    `HRFA_ASSERT(a_bo_zero_not_read, ((state_reg == hrfa_pkg::S_DONE) && (func_reg != hrfa_pkg::FUNC_READ)) |-> (res_bo_reg == 8'h00), "byte out set by non-read item")

endmodule

// File: tb/sv/hid_report_field_access_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// hid_report_field_access_test
// Sends byte load, byte read, field insert and field extract items to the
// report field access block under varied back-pressure. Each response is
// checked against a tracked copy of the report buffer.
// ---------------------------------------------------------------------------

typedef struct {
    hrfa_pkg::func_t    op;
    logic [5:0]         byte_index;
    logic [7:0]         byte_data;
    logic [7:0]         bit_offset;
    logic [5:0]         field_size;
    logic signed [32:0] log_min;
    logic signed [32:0] log_max;
    logic [31:0]        write_bits;
} access_req_t;

typedef struct {
    logic signed [32:0] field_value;
    logic [7:0]         byte_out;
} access_rsp_t;

class report_field_scoreboard;
    logic [7:0]  image [hrfa_pkg::REPORT_BYTES_DEF];
    access_rsp_t pending_results [$];
    int          error_count;

    function new();
        foreach (image[i])
            image[i] = 8'h00;
        error_count = 0;
    endfunction

    // Apply one accepted item to the buffer image and queue its response.
    function void note_access(access_req_t r);
        access_rsp_t     res;
        int unsigned     start;
        int unsigned     size;
        int unsigned     pos;
        int unsigned     w;
        int              h;
        longint          lo;
        longint          hi;
        longint          val;
        longint unsigned raw;
        longint unsigned mag_lo;
        longint unsigned mag_hi;
        longint unsigned mag;
        longint unsigned sign_bit;
        longint unsigned mask;

        res.field_value = '0;
        res.byte_out    = '0;
        start = r.bit_offset + hrfa_pkg::ID_BITS;
        size  = (r.field_size > hrfa_pkg::MAX_FIELD) ? hrfa_pkg::MAX_FIELD : r.field_size;
        case (r.op)
            hrfa_pkg::FUNC_LOAD:
            begin
                if (r.byte_index < hrfa_pkg::REPORT_BYTES_DEF)
                    image[r.byte_index] = r.byte_data;
            end
            hrfa_pkg::FUNC_READ:
            begin
                if (r.byte_index < hrfa_pkg::REPORT_BYTES_DEF)
                    res.byte_out = image[r.byte_index];
            end
            hrfa_pkg::FUNC_INSERT:
            begin
                for (w = 0; w < size; w++)
                begin
                    pos = start + w;
                    // drop bits past the end of the buffer
                    if ((pos >> 3) < hrfa_pkg::REPORT_BYTES_DEF)
                        image[pos >> 3][pos & 7] = r.write_bits[w];
                end
            end
            default:
            begin
                raw = 0;
                for (w = 0; w < size; w++)
                begin
                    pos = start + w;
                    if ((pos >> 3) < hrfa_pkg::REPORT_BYTES_DEF && image[pos >> 3][pos & 7])
                        raw |= 64'd1 << w;
                end
                lo = r.log_min;
                hi = r.log_max;
                mag_lo = (lo >= 0) ? lo : -(lo + 1);
                mag_hi = (hi >= 0) ? hi : -(hi + 1);
                mag = (mag_hi > mag_lo) ? mag_hi : mag_lo;
                h = 0;
                while (mag != 0)
                begin
                    mag >>= 1;
                    h++;
                end
                sign_bit = 64'd1 << h;
                mask = sign_bit - 1;
                if (lo < 0)
                    mask |= sign_bit;
                raw &= mask;
                if (lo < 0 && (raw & sign_bit) != 0)
                    val = longint'(raw & (sign_bit - 1)) - longint'(sign_bit);
                else
                    val = longint'(raw);
                // test the minimum first: an inverted pair yields log_min below it, else log_max
                if (val < lo)
                    val = lo;
                else if (val > hi)
                    val = hi;
                res.field_value = val[32:0];
            end
        endcase
        pending_results.push_back(res);
    endfunction

    function void check_result(access_rsp_t got);
        access_rsp_t want;

        if (pending_results.size() == 0)
        begin
            $error("unexpected item: field_value %0d, byte_out 0x%02h",
                   got.field_value, got.byte_out);
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        if (got.field_value !== want.field_value)
        begin
            $error("field_value: expected %0d, actual %0d", want.field_value, got.field_value);
            error_count++;
        end
        if (got.byte_out !== want.byte_out)
        begin
            $error("byte_out: expected 0x%02h, actual 0x%02h", want.byte_out, got.byte_out);
            error_count++;
        end
    endfunction
endclass

module hid_report_field_access_test;

    localparam int     HOLD_CYCLES  = 300;
    localparam int     DRAIN_CYCLES = 24;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     PHASE_ITEMS  = 365;
    localparam longint U32_MAX      = 64'sd4294967295;
    localparam longint S32_MAX      = 64'sd2147483647;
    localparam longint S32_MIN      = -64'sd2147483648;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   hold_start;
    logic                   hold_off;
    int                     rx_stall_pct;
    int                     tx_idle_pct;
    int                     cycle_count = 0;
    logic [7:0]             last_offset;
    logic [5:0]             last_size;
    access_rsp_t            seen_rsp;
    report_field_scoreboard board;

    hrfa_req_if req_ch ();
    hrfa_rsp_if rsp_ch ();

    hid_report_field_access #(.REPORT_BYTES(hrfa_pkg::REPORT_BYTES_DEF)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("hid_report_field_access_test failed");
            $finish;
        end
    end

    // Response side: check each accepted item, then pick the next ready.
    always @(posedge clk)
    begin
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            seen_rsp.field_value = rsp_ch.field_value;
            seen_rsp.byte_out    = rsp_ch.byte_out;
            board.check_result(seen_rsp);
        end
        if (!rst_n || hold_off)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Long receiver hold-off so the block backs up into the request side.
    initial
    begin : rx_hold
        int n;

        hold_off = 1'b0;
        wait (hold_start === 1'b1);
        @(posedge clk);
        hold_off <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++)
            @(posedge clk);
        hold_off <= 1'b0;
    end

    function automatic access_req_t make_access(hrfa_pkg::func_t op, logic [5:0] idx,
                                                logic [7:0] data, logic [7:0] off,
                                                logic [5:0] size, longint lo, longint hi,
                                                logic [31:0] wbits);
        access_req_t r;

        r.op         = op;
        r.byte_index = idx;
        r.byte_data  = data;
        r.bit_offset = off;
        r.field_size = size;
        r.log_min    = 33'(lo);
        r.log_max    = 33'(hi);
        r.write_bits = wbits;
        return r;
    endfunction

    function automatic longint random_bound();
        longint v;

        v = longint'($urandom);
        if ($urandom_range(2) == 0)
            v = v - 64'sd2147483648;
        return v;
    endfunction

    function automatic access_req_t random_access();
        access_req_t r;
        int          pick;
        int          n;

        r = make_access(hrfa_pkg::FUNC_LOAD, 6'($urandom_range(63)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 6'($urandom_range(63)),
                        random_bound(), random_bound(), $urandom);
        pick = $urandom_range(99);
        if (pick < 20)
            r.op = hrfa_pkg::FUNC_LOAD;
        else if (pick < 35)
            r.op = hrfa_pkg::FUNC_READ;
        else
        begin
            r.op = (pick < 60) ? hrfa_pkg::FUNC_INSERT : hrfa_pkg::FUNC_EXTRACT;
            n = $urandom_range(99);
            if (n < 90)
                r.field_size = 6'($urandom_range(32, 1));
            else if (n < 95)
                r.field_size = 6'd0;
            else
                r.field_size = 6'($urandom_range(63, 33));
            // aim half of the extracts at the most recently written field
            if (r.op == hrfa_pkg::FUNC_EXTRACT && $urandom_range(1) == 1)
            begin
                r.bit_offset = last_offset;
                r.field_size = last_size;
            end
            if (r.op == hrfa_pkg::FUNC_INSERT)
            begin
                last_offset = r.bit_offset;
                last_size   = r.field_size;
            end
            else
            begin
                n = int'(r.field_size);
                if (n == 0)
                    n = 1;
                if (n > hrfa_pkg::MAX_FIELD)
                    n = hrfa_pkg::MAX_FIELD;
                case ($urandom_range(3))
                    0:
                    begin
                        r.log_min = 33'sd0;
                        r.log_max = 33'((64'sd1 << n) - 1);
                    end
                    1:
                    begin
                        r.log_min = 33'(-(64'sd1 << (n - 1)));
                        r.log_max = 33'((64'sd1 << (n - 1)) - 1);
                    end
                    2:
                    begin
                        r.log_min = 33'(int'($urandom_range(40)) - 20);
                        r.log_max = 33'(int'($urandom_range(40)) - 20);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        return r;
    endfunction

    // Offer one item, idling first at the current rate, and hold until taken.
    task automatic offer_access(input access_req_t r);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= r.op;
        req_ch.byte_index <= r.byte_index;
        req_ch.byte_data  <= r.byte_data;
        req_ch.bit_offset <= r.bit_offset;
        req_ch.field_size <= r.field_size;
        req_ch.log_min    <= r.log_min;
        req_ch.log_max    <= r.log_max;
        req_ch.write_bits <= r.write_bits;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        board.note_access(r);
    endtask

    initial
    begin
        int phase_idx;
        int item_idx;

        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.func       = hrfa_pkg::FUNC_LOAD;
        req_ch.byte_index = '0;
        req_ch.byte_data  = '0;
        req_ch.bit_offset = '0;
        req_ch.field_size = '0;
        req_ch.log_min    = '0;
        req_ch.log_max    = '0;
        req_ch.write_bits = '0;
        hold_start        = 1'b0;
        rx_stall_pct      = 0;
        tx_idle_pct       = 0;
        last_offset       = '0;
        last_size         = 6'd1;
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset contents, buffer ends, field extremes, bound corner cases
        offer_access(make_access(hrfa_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0));
        offer_access(make_access(hrfa_pkg::FUNC_READ, 63, 0, 0, 0, 0, 0, 0));
        offer_access(make_access(hrfa_pkg::FUNC_LOAD, 0, 8'hff, 0, 0, 0, 0, 0));
        offer_access(make_access(hrfa_pkg::FUNC_LOAD, 63, 8'ha5, 0, 0, 0, 0, 0));
        offer_access(make_access(hrfa_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0));
        offer_access(make_access(hrfa_pkg::FUNC_READ, 63, 0, 0, 0, 0, 0, 0));
        offer_access(make_access(hrfa_pkg::FUNC_INSERT, 0, 0, 0, 32, 0, 0, 32'hffffffff));
        offer_access(make_access(hrfa_pkg::FUNC_EXTRACT, 0, 0, 0, 32, 0, U32_MAX, 0));
        offer_access(make_access(hrfa_pkg::FUNC_EXTRACT, 0, 0, 0, 32, S32_MIN, S32_MAX, 0));
        offer_access(make_access(hrfa_pkg::FUNC_INSERT, 0, 0, 255, 32, 0, 0, 32'h12345678));
        offer_access(make_access(hrfa_pkg::FUNC_EXTRACT, 0, 0, 255, 32, 0, U32_MAX, 0));
        offer_access(make_access(hrfa_pkg::FUNC_READ, 36, 0, 0, 0, 0, 0, 0));
        offer_access(make_access(hrfa_pkg::FUNC_INSERT, 0, 0, 100, 0, 0, 0, 32'hffffffff));
        offer_access(make_access(hrfa_pkg::FUNC_EXTRACT, 0, 0, 100, 8, 0, 255, 0));
        offer_access(make_access(hrfa_pkg::FUNC_INSERT, 0, 0, 3, 45, 0, 0, 32'ha5a5a5a5));
        offer_access(make_access(hrfa_pkg::FUNC_EXTRACT, 0, 0, 3, 63, 0, U32_MAX, 0));
        offer_access(make_access(hrfa_pkg::FUNC_EXTRACT, 0, 0, 40, 0, -5, 5, 0));
        offer_access(make_access(hrfa_pkg::FUNC_EXTRACT, 0, 0, 0, 8, 0, 0, 0));
        offer_access(make_access(hrfa_pkg::FUNC_EXTRACT, 0, 0, 0, 8, -1, 0, 0));
        offer_access(make_access(hrfa_pkg::FUNC_LOAD, 2, 8'h04, 0, 0, 0, 0, 0));
        offer_access(make_access(hrfa_pkg::FUNC_EXTRACT, 0, 0, 8, 3, -3, 3, 0));
        offer_access(make_access(hrfa_pkg::FUNC_EXTRACT, 0, 0, 0, 8, 0, 10, 0));
        offer_access(make_access(hrfa_pkg::FUNC_EXTRACT, 0, 0, 0, 8, 100, 10, 0));
        offer_access(make_access(hrfa_pkg::FUNC_LOAD, 3, 8'hff, 0, 0, 0, 0, 0));
        offer_access(make_access(hrfa_pkg::FUNC_EXTRACT, 0, 0, 16, 8, 100, 10, 0));

        for (phase_idx = 0; phase_idx < 5; phase_idx++)
        begin
            case (phase_idx)
                0:
                begin
                    tx_idle_pct   = 0;
                    rx_stall_pct <= 0;
                end
                1:
                begin
                    tx_idle_pct   = 74;
                    rx_stall_pct <= 0;
                end
                2:
                begin
                    tx_idle_pct   = 0;
                    rx_stall_pct <= 74;
                end
                3:
                begin
                    tx_idle_pct   = 29;
                    rx_stall_pct <= 29;
                end
                default:
                begin
                    tx_idle_pct   = 0;
                    rx_stall_pct <= 0;
                    hold_start    = 1'b1;
                end
            endcase
            for (item_idx = 0; item_idx < PHASE_ITEMS; item_idx++)
                offer_access(random_access());
        end

        req_ch.valid <= 1'b0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.error_count == 0)
            $display("hid_report_field_access_test passed");
        else
            $display("hid_report_field_access_test failed");
        $finish;
    end
endmodule
